>>> rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, operation codes and status codes for the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

endpackage

>>> rtl/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider
// Pipelined restoring divider: magnitude quotient of num / den, one quotient
// bit per stage, with a payload of side data carried alongside.
// Every stage moves together under the enable and holds while it is low.
// ----------------------------------------------------------------------------
module cau_divider
    import cau_pkg::*;
#(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 33,
    parameter int QUO_W  = 18,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    // The numerator's bits above QUO_W seed the remainder; the low QUO_W bits
    // are shifted in one per stage. A quotient of 2**(QUO_W-1) or more
    // saturates to all ones.
    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0]  rem_reg  [QUO_W+1];
    logic [NUM_W-1:0]  num_reg  [QUO_W+1];
    logic [DEN_W-1:0]  den_reg  [QUO_W+1];
    logic [QUO_W-1:0]  quo_reg  [QUO_W+1];
    logic [SIDE_W-1:0] side_reg [QUO_W+1];

    // Stage 0: load. Quotient bits from QUO_W-1 up are only tested for
    // overflow: if num >> (QUO_W-1) >= den, the quotient saturates to all ones.
    logic [NUM_W-1:0] num_hi;
    logic             ovf;
    assign num_hi = in_num >> (QUO_W - 1);
    assign ovf    = ({{DEN_W{1'b0}}, num_hi} >= {{NUM_W{1'b0}}, in_den});

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= ovf ? '0 : REM_W'(in_num >> QUO_W);
            num_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= ovf ? '1 : '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int BIT = QUO_W - 1 - s;
        logic [REM_W-1:0] trial;
        logic [REM_W:0]   diff;
        assign trial = {rem_reg[s][REM_W-2:0], num_reg[s][BIT]};
        assign diff  = {1'b0, trial} - {2'b00, den_reg[s]};
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[s+1]  <= num_reg[s];
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
                if (s == 0 && quo_reg[s] == '1) begin
                    rem_reg[s+1] <= '0;
                    quo_reg[s+1] <= quo_reg[s];
                end else if (!diff[REM_W]) begin
                    rem_reg[s+1] <= diff[REM_W-1:0];
                    quo_reg[s+1] <= quo_reg[s] | (QUO_W'(1) << BIT);
                end else begin
                    rem_reg[s+1] <= trial;
                    quo_reg[s+1] <= quo_reg[s];
                end
            end
        end
    end

    assign out_quo  = quo_reg[QUO_W];
    assign out_side = side_reg[QUO_W];

endmodule

>>> rtl/complex_arithmetic_unit.sv
// Path: operand, product and combine registers, then the DATA_WIDTH + 2
//   divider stages, then the output register; the default format is Q8.8.
// Throughput: one word per cycle; the pipeline advances whenever the
//   output register is empty or being taken. Every mode takes the same path.
// Reset: aresetn (synchronous, active low) clears all valid bits; the
//   data registers are not reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed fixed-point operands,
// saturated results with status.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_mode,
    input  logic signed [DATA_WIDTH-1:0] s_first_real,
    input  logic signed [DATA_WIDTH-1:0] s_first_imag,
    input  logic signed [DATA_WIDTH-1:0] s_second_real,
    input  logic signed [DATA_WIDTH-1:0] s_second_imag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_result_real,
    output logic signed [DATA_WIDTH-1:0] m_result_imag,
    output logic [1:0]                   m_status
);

    localparam int DW    = DATA_WIDTH;
    localparam int PW    = 2 * DW;         // product
    localparam int SW    = PW + 1;         // sum of two products
    localparam int NUM_W = SW + FRAC_BITS; // scaled numerator magnitude
    localparam int QUO_W = DW + 1;         // enough to flag overflow
    localparam int DIV_LAT = QUO_W + 1;
    localparam int LAT   = DIV_LAT + 3;    // stages before output register
    localparam int SIDE_W = 2 + 2 * SW + 2;

    // Global advance: the whole pipe moves unless the output holds a word that is not taken.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic [LAT-1:0] vld_reg;

    // Stage 1: register operands
    logic [1:0]          mode_reg;
    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            mode_reg <= s_mode;
            ar_reg   <= s_first_real;
            ai_reg   <= s_first_imag;
            br_reg   <= s_second_real;
            bi_reg   <= s_second_imag;
        end
    end

    // Stage 2: four products, sums for add/sub
    logic [1:0]           mode2_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [DW:0]   as_re_reg, as_im_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            mode2_reg <= mode_reg;
            p_rr_reg  <= ar_reg * br_reg;
            p_ii_reg  <= ai_reg * bi_reg;
            p_ri_reg  <= ar_reg * bi_reg;
            p_ir_reg  <= ai_reg * br_reg;
            if (mode_reg == OP_SUB) begin
                as_re_reg <= (DW+1)'(ar_reg) - (DW+1)'(br_reg);
                as_im_reg <= (DW+1)'(ai_reg) - (DW+1)'(bi_reg);
            end else begin
                as_re_reg <= (DW+1)'(ar_reg) + (DW+1)'(br_reg);
                as_im_reg <= (DW+1)'(ai_reg) + (DW+1)'(bi_reg);
            end
        end
    end

    // Stage 3: combine products; form divider numerators
    logic signed [SW-1:0] re_s, im_s;
    always_comb begin
        re_s  = '0;
        im_s  = '0;
        case (mode2_reg)
            OP_MUL: begin
                re_s = SW'(p_rr_reg) - SW'(p_ii_reg);
                im_s = SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            OP_DIV: begin
                re_s = SW'(p_rr_reg) + SW'(p_ii_reg);
                im_s = SW'(p_ir_reg) - SW'(p_ri_reg);
            end
            default: begin
                re_s = SW'(as_re_reg);
                im_s = SW'(as_im_reg);
            end
        endcase
    end

    // Denominator squares, in step with the products
    logic signed [PW-1:0] bb_r_reg, bb_i_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            bb_r_reg <= br_reg * br_reg;
            bb_i_reg <= bi_reg * bi_reg;
        end
    end

    logic [1:0]          mode3_reg;
    logic signed [SW-1:0] re3_reg, im3_reg;
    logic [SW-1:0]       den3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            mode3_reg <= mode2_reg;
            re3_reg   <= re_s;
            im3_reg   <= im_s;
            den3_reg  <= SW'(bb_r_reg) + SW'(bb_i_reg);
        end
    end

    // Magnitudes and scaled numerators into two dividers
    logic [SW-1:0]    re_mag, im_mag;
    logic [NUM_W-1:0] re_num, im_num;
    logic [SW-1:0]    den_in;
    logic             dz_in;
    assign re_mag = re3_reg[SW-1] ? SW'(-re3_reg) : SW'(re3_reg);
    assign im_mag = im3_reg[SW-1] ? SW'(-im3_reg) : SW'(im3_reg);
    assign re_num = {re_mag, {FRAC_BITS{1'b0}}};
    assign im_num = {im_mag, {FRAC_BITS{1'b0}}};
    assign dz_in  = (den3_reg == '0);
    assign den_in = dz_in ? SW'(1) : den3_reg;

    logic [SIDE_W-1:0] side_in, side_re;
    logic              dz_o;
    assign side_in = {mode3_reg, re3_reg, im3_reg, re3_reg[SW-1], im3_reg[SW-1]};

    logic [QUO_W-1:0] q_re, q_im;
    cau_divider #(.NUM_W(NUM_W), .DEN_W(SW), .QUO_W(QUO_W), .SIDE_W(SIDE_W))
    u_div_re (.aclk(aclk), .en(adv), .in_num(re_num), .in_den(den_in),
              .in_side(side_in), .out_quo(q_re), .out_side(side_re));
    cau_divider #(.NUM_W(NUM_W), .DEN_W(SW), .QUO_W(QUO_W), .SIDE_W(1))
    u_div_im (.aclk(aclk), .en(adv), .in_num(im_num), .in_den(den_in),
              .in_side(dz_in), .out_quo(q_im), .out_side(dz_o));

    // Unpack carried data
    logic [1:0]          mode_o;
    logic signed [SW-1:0] re_o, im_o;
    logic                neg_re, neg_im;
    assign {mode_o, re_o, im_o, neg_re, neg_im} = side_re;

    // Output stage: pick result per mode, saturate
    localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (DW-1)) - 1);
    localparam logic signed [SW-1:0] MINV = -SW'(64'sd1 <<< (DW-1));

    logic signed [SW-1:0] vr, vi;
    logic signed [DW-1:0] rr_n, ri_n;
    logic                 sat_r, sat_i;
    logic [1:0]           st_n;
    always_comb begin
        case (mode_o)
            OP_MUL: begin
                vr = re_o >>> FRAC_BITS;
                vi = im_o >>> FRAC_BITS;
            end
            OP_DIV: begin
                vr = neg_re ? -SW'(q_re) : SW'(q_re);
                vi = neg_im ? -SW'(q_im) : SW'(q_im);
            end
            default: begin
                vr = re_o;
                vi = im_o;
            end
        endcase
        sat_r = (vr > MAXV) || (vr < MINV);
        sat_i = (vi > MAXV) || (vi < MINV);
        rr_n  = (vr > MAXV) ? DW'(MAXV) : (vr < MINV) ? DW'(MINV) : DW'(vr);
        ri_n  = (vi > MAXV) ? DW'(MAXV) : (vi < MINV) ? DW'(MINV) : DW'(vi);
        st_n  = (sat_r || sat_i) ? ST_SAT : ST_OK;
        if (mode_o == OP_DIV && dz_o) begin
            rr_n = '0;
            ri_n = '0;
            st_n = ST_DIV0;
        end
    end

    logic signed [DW-1:0] rr_reg, ri_reg;
    logic [1:0]           st_reg;
    logic                 mv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            mv_reg  <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
            mv_reg  <= vld_reg[LAT-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            rr_reg <= rr_n;
            ri_reg <= ri_n;
            st_reg <= st_n;
        end
    end

    assign m_valid       = mv_reg;
    assign m_result_real = rr_reg;
    assign m_result_imag = ri_reg;
    assign m_status      = st_reg;

`ifndef SYNTH
    // Output valid, real part and status hold while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_real) && $stable(m_status))
        else $error("output changed under stall");
    // Status code never reserved
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != ST_RSVD)
        else $error("reserved status");
    // Divide by zero gives zero parts
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DIV0 |-> m_result_real == '0 && m_result_imag == '0)
        else $error("div0 result not zero");
    // Valid bits frozen during stall
    a_frz: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipe moved under stall");
`endif

endmodule
